@@ hw/rtl/sum_of_two_squares_test_macros.svh @@
// Assertion macros shared by the sum-of-two-squares test RTL.
// The macros expect signals named clk and arst_n in the module that uses them.
`ifndef SUM_OF_TWO_SQUARES_TEST_MACROS_SVH
`define SUM_OF_TWO_SQUARES_TEST_MACROS_SVH
`ifndef ASSERT_OFF
`define SOTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SOTS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SOTS_ASSERT(lbl, prop, msg)
`define SOTS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hw/rtl/sots_pkg.sv @@
// Shared types for the sum-of-two-squares test block.
// Command and status structs that join the controller and the datapath.
package sots_pkg;

	typedef struct packed {
		logic load;       // capture a new value and start the square root
		logic sqrt_step;  // one digit of the square root
		logic walk_init;  // seed the two pointers from the root
		logic walk_step;  // move one pointer
	} sots_cmd_t;

	typedef struct packed {
		logic perfect;    // remainder of the root is zero
		logic found;      // current pointer pair matches the value
		logic stop;       // pointers crossed or no smaller pointer left
	} sots_status_t;

endpackage

@@ hw/rtl/sots_if.sv @@
// Valid/ready channel interfaces for the sum-of-two-squares test block.
// No dependencies.
interface sots_value_if #(
	parameter int VALUE_WIDTH = 31
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sots_result_if;
	logic valid;
	logic ready;
	logic is_sum_of_squares;

	modport source (output valid, output is_sum_of_squares, input ready);
	modport sink   (input valid, input is_sum_of_squares, output ready);
endinterface

@@ hw/rtl/sum_of_two_squares_test.sv @@
// Top level of the sum-of-two-squares test block.
// Depends on sots_pkg, sots_if, sots_controller and sots_datapath.
//
//   channel  direction  payload               handshake
//   req      in         value[VALUE_WIDTH-1:0] valid/ready
//   rsp      out        is_sum_of_squares      valid/ready
//
// One item at a time: the idle state takes the transfer, then (VALUE_WIDTH+1)/2 root digits,
// a check state, one pointer move per cycle until the walk ends, and a state to register.
// The walk makes at most floor(sqrt(value))+1 moves, 46341 at the largest 31-bit value; each
// move is one add and compare.
// Reset is asynchronous, active low, and leaves the block idle with no result.
// A new item is taken while an earlier result waits; only registering a result can stall.
module sum_of_two_squares_test #(
	parameter int VALUE_WIDTH = 31
) (
	input logic         clk,
	input logic         arst_n,
	sots_value_if.sink  req,
	sots_result_if.source rsp
);
	import sots_pkg::*;

	localparam int SB = (VALUE_WIDTH + 1) / 2;

	sots_cmd_t    cmd;
	sots_status_t status;

	sots_controller #(
		.SQRT_BITS (SB)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_bit   (rsp.is_sum_of_squares),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sots_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (req.value),
		.cmd    (cmd),
		.status (status)
	);
endmodule

@@ hw/rtl/sots_datapath.sv @@
// Datapath: digit-by-digit integer square root and the two-pointer walk.
// Depends on sots_pkg for the command and status structs.
module sots_datapath #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [VALUE_WIDTH-1:0]   value,
	input  sots_pkg::sots_cmd_t      cmd,
	output sots_pkg::sots_status_t   status
);
	import sots_pkg::*;

	localparam int SB  = (VALUE_WIDTH + 1) / 2;
	localparam int W2  = 2 * SB;
	localparam int SQW = W2 + 1;

	logic [W2-1:0]  v_q;
	logic [W2-1:0]  op_q;
	logic [W2-1:0]  res_q;
	logic [W2-1:0]  one_q;
	logic [SB:0]    lo_q;
	logic [SB-1:0]  hi_q;
	logic [SQW-1:0] lo_sq_q;
	logic [SQW-1:0] hi_sq_q;

	logic [W2:0]    trial;
	logic           take;
	logic [SQW:0]   sum;
	logic [SQW:0]   v_ext;
	logic           crossed;
	logic           over;

	assign trial   = {1'b0, res_q} + {1'b0, one_q};
	assign take    = {1'b0, op_q} >= trial;
	assign sum     = {1'b0, lo_sq_q} + {1'b0, hi_sq_q};
	assign v_ext   = {2'b00, v_q};
	assign crossed = lo_q > {1'b0, hi_q};
	assign over    = sum > v_ext;

	assign status.perfect = op_q == '0;
	assign status.found   = !crossed && (sum == v_ext);
	assign status.stop    = crossed || (over && hi_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= W2'(value);
			op_q  <= W2'(value);
			res_q <= '0;
			one_q <= W2'(1) << (W2 - 2);
		end else if (cmd.sqrt_step) begin
			if (take) begin
				op_q  <= op_q - trial[W2-1:0];
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end

		if (cmd.walk_init) begin
			// The root squared is the value less the remainder.
			lo_q    <= '0;
			lo_sq_q <= '0;
			hi_q    <= res_q[SB-1:0];
			hi_sq_q <= SQW'(v_q - op_q);
		end else if (cmd.walk_step) begin
			if (over) begin
				hi_q    <= hi_q - 1'b1;
				hi_sq_q <= hi_sq_q - {{(SQW-SB-1){1'b0}}, hi_q, 1'b0} + SQW'(1);
			end else begin
				lo_q    <= lo_q + 1'b1;
				lo_sq_q <= lo_sq_q + {{(SQW-SB-2){1'b0}}, lo_q, 1'b0} + SQW'(1);
			end
		end
	end

	// arst_n is used only by the assertions; the datapath holds no control state.
`include "sum_of_two_squares_test_macros.svh"
	`SOTS_ASSERT(a_rem_bound, cmd.walk_init |-> ({1'b0, op_q} <= {res_q, 1'b0}), "root remainder too large")
	`SOTS_ASSERT(a_hi_sq_track, cmd.walk_step |=> (hi_sq_q == SQW'({{SB{1'b0}}, hi_q} * {{SB{1'b0}}, hi_q})), "falling square lost track")
	`SOTS_ASSERT_NEVER(a_dead_step, cmd.walk_step && status.stop, "pointer moved after the walk ended")
endmodule

@@ hw/rtl/sots_controller.sv @@
// Controller: sequences square root, pointer walk and the result register.
// Depends on sots_pkg for the command and status structs.
module sots_controller #(
	parameter int SQRT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	output logic                   rsp_bit,
	input  logic                   rsp_ready,
	input  sots_pkg::sots_status_t status,
	output sots_pkg::sots_cmd_t    cmd
);
	import sots_pkg::*;

	localparam int CW = (SQRT_BITS > 1) ? $clog2(SQRT_BITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CHECK,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          fin_q;
	logic          out_valid_q;
	logic          out_bit_q;
	logic          out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = out_valid_q;
	assign rsp_bit   = out_bit_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && req_valid;
		cmd.sqrt_step = state_q == ST_SQRT;
		cmd.walk_init = state_q == ST_CHECK;
		cmd.walk_step = (state_q == ST_WALK) && !status.found && !status.stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			// In ST_FIN the result register is reloaded below instead.
			if (out_valid_q && rsp_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SQRT_BITS - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.perfect) begin
						fin_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (status.found) begin
						fin_q   <= 1'b1;
						state_q <= ST_FIN;
					end else if (status.stop) begin
						fin_q   <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Wait here while an earlier result is still unclaimed.
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_bit_q   <= fin_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "sum_of_two_squares_test_macros.svh"
	`SOTS_ASSERT(a_accept_starts, (req_valid && req_ready) |=> (state_q == ST_SQRT), "transfer did not start the root")
	`SOTS_ASSERT(a_sqrt_exit, (state_q == ST_SQRT) |=> (state_q == ST_SQRT || state_q == ST_CHECK), "root search left early")
	`SOTS_ASSERT(a_fin_loads, (state_q == ST_FIN && out_free) |=> out_valid_q, "result not registered")
	`SOTS_ASSERT(a_take_clears, (out_valid_q && rsp_ready && state_q != ST_FIN) |=> !out_valid_q, "result repeated")
endmodule
